// ----- rtl/lbp_pixel_operator_macros.svh -----
// Assertion macros shared by the LBP operator RTL.
`ifndef LBP_PIXEL_OPERATOR_MACROS_SVH
`define LBP_PIXEL_OPERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lbp_pkg.sv -----
// Shared constants and types of the LBP operator.
`timescale 1ns / 1ps

package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int FILL_W     = $clog2(MAX_WIDTH + 2);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int COUNT_W    = 22;
  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [COUNT_W-1:0]  TOTAL_RESET  = COUNT_W'(640 * 480);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int DIV_STEPS = COUNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_PIXEL_OUT,
    KIND_DRAIN_OUT
  } lbp_kind_t;

  typedef struct packed {
    lbp_kind_t          kind;
    logic [COL_W-1:0]   addr;
    logic [PIX_W-1:0]   pixel;
    logic               border;
    logic               eof;
    logic               sel_upper;
  } lbp_entry_t;

endpackage

// ----- rtl/lbp_div.sv -----
// Restoring divider, one quotient bit per cycle: output position from a flat pixel count.
`timescale 1ns / 1ps
`include "lbp_pixel_operator_macros.svh"

module lbp_div import lbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COUNT_W-1:0] dividend,
  input  logic [WIDTH_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [COUNT_W-1:0] quot,
  output logic [WIDTH_W-1:0] rem
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0]   quot_r;
  logic [WIDTH_W-1:0]   rem_r;
  logic [WIDTH_W-1:0]   div_r;
  logic [WIDTH_W:0]     trial;
  logic [WIDTH_W:0]     diff;
  logic                 ge;

  always_comb begin
    trial = {rem_r, quot_r[COUNT_W-1]};
    ge    = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[COUNT_W-2:0], ge};
      rem_r  <= ge ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

  `LBP_ASSERT_IMP(a_div_rem_below_divisor, done_r, rem_r < div_r, "divider remainder not reduced")

endmodule

// ----- rtl/lbp_front.sv -----
// Front end: config registers, raster counters, item classification into queue entries.
`timescale 1ns / 1ps
`include "lbp_pixel_operator_macros.svh"

module lbp_front import lbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,
  input  logic                  in_tuser,
  input  logic                  fifo_full,
  output logic                  push,
  output lbp_entry_t            push_entry
);

  logic [WIDTH_W-1:0]  frame_width_r, frame_width_nxt;
  logic [HEIGHT_W-1:0] frame_height_r, frame_height_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [HEIGHT_W-1:0] in_row_r, in_row_nxt;
  logic [FILL_W-1:0]   pipe_fill_r, pipe_fill_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [COUNT_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic                settle_r;
  logic                wstart_r;

  logic [WIDTH_W-1:0]          w_used;
  logic [HEIGHT_W-1:0]         h_used;
  logic [WIDTH_W+HEIGHT_W-1:0] area;
  logic                        busy;
  logic                        accept;
  logic                        is_pixel;
  logic                        pix_fire;
  logic                        drain_fire;
  logic                        out_fire;
  logic                        col_wrap;
  logic                        row_wrap;
  logic                        out_last;
  logic                        out_col_wrap;
  logic                        border;
  logic                        div_busy;
  logic                        div_done;
  logic [COUNT_W-1:0]          div_quot;
  logic [WIDTH_W-1:0]          div_rem;

  lbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (wstart_r),
    .dividend (out_count_r),
    .divisor  (w_used),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    w_used = frame_width_r;
    if (frame_width_r == '0) begin
      w_used = WIDTH_W'(1);
    end else if (frame_width_r > WIDTH_MAX) begin
      w_used = WIDTH_MAX;
    end
    h_used = (frame_height_r == '0) ? HEIGHT_W'(1) : frame_height_r;
    area   = (WIDTH_W+HEIGHT_W)'(w_used) * (WIDTH_W+HEIGHT_W)'(h_used);
  end

  assign busy      = settle_r || div_busy || div_done;
  assign in_tready = !fifo_full && !busy;
  assign accept    = in_tvalid && in_tready;
  assign is_pixel  = in_tuser == OP_PIXEL;

  always_comb begin
    pix_fire     = pipe_fill_r > FILL_W'(w_used);
    drain_fire   = (pipe_fill_r != '0) && (in_row_r == '0) && (in_col_r == '0);
    out_fire     = accept && (is_pixel ? pix_fire : drain_fire);
    col_wrap     = ({1'b0, in_col_r} + (COL_W+1)'(1)) >= (COL_W+1)'(w_used);
    row_wrap     = ({1'b0, in_row_r} + (HEIGHT_W+1)'(1)) >= {1'b0, h_used};
    out_last     = ({1'b0, out_count_r} + (COUNT_W+1)'(1)) >= {1'b0, total_r};
    out_col_wrap = ({1'b0, out_col_r} + (COL_W+1)'(1)) >= (COL_W+1)'(w_used);
    border       = (out_row_r == '0)
                || (({1'b0, out_row_r} + (COUNT_W+1)'(1)) >= (COUNT_W+1)'(h_used))
                || (out_col_r == '0) || out_col_wrap;
  end

  always_comb begin
    push                 = accept && (is_pixel || drain_fire);
    push_entry.kind      = !is_pixel ? KIND_DRAIN_OUT : (pix_fire ? KIND_PIXEL_OUT : KIND_PIXEL);
    push_entry.addr      = is_pixel ? in_col_r : out_col_r;
    push_entry.pixel     = in_tdata;
    push_entry.border    = border;
    push_entry.eof       = out_last;
    push_entry.sel_upper = pipe_fill_r > FILL_W'(w_used);
  end

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata[HEIGHT_W-1:0];
      endcase
    end
    total_nxt = area[COUNT_W-1:0];

    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (accept && is_pixel) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = row_wrap ? '0 : in_row_r + HEIGHT_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end

    pipe_fill_nxt = pipe_fill_r;
    if (accept && is_pixel && !pix_fire) begin
      pipe_fill_nxt = pipe_fill_r + FILL_W'(1);
    end else if (accept && !is_pixel && drain_fire) begin
      pipe_fill_nxt = pipe_fill_r - FILL_W'(1);
    end

    out_count_nxt = out_count_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    if (div_done) begin
      out_row_nxt = div_quot;
      out_col_nxt = div_rem[COL_W-1:0];
    end else if (out_fire) begin
      if (out_last) begin
        out_count_nxt = '0;
        out_row_nxt   = '0;
        out_col_nxt   = '0;
      end else begin
        out_count_nxt = out_count_r + COUNT_W'(1);
        if (out_col_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + COUNT_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      total_r        <= TOTAL_RESET;
      in_col_r       <= '0;
      in_row_r       <= '0;
      pipe_fill_r    <= '0;
      out_count_r    <= '0;
      out_row_r      <= '0;
      out_col_r      <= '0;
      settle_r       <= 1'b0;
      wstart_r       <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      total_r        <= total_nxt;
      in_col_r       <= in_col_nxt;
      in_row_r       <= in_row_nxt;
      pipe_fill_r    <= pipe_fill_nxt;
      out_count_r    <= out_count_nxt;
      out_row_r      <= out_row_nxt;
      out_col_r      <= out_col_nxt;
      settle_r       <= cfg_we;
      wstart_r       <= cfg_we && (cfg_index == REG_FRAME_WIDTH);
    end
  end

  `LBP_ASSERT_IMP(a_out_col_in_range, !busy, (COL_W+1)'(out_col_r) < (COL_W+1)'(w_used), "output column beyond width")

endmodule

// ----- rtl/lbp_fifo.sv -----
// Short queue of classified entries between front and back.
`timescale 1ns / 1ps
`include "lbp_pixel_operator_macros.svh"

module lbp_fifo import lbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lbp_entry_t push_entry,
  input  logic       pop,
  output lbp_entry_t head,
  output logic       empty,
  output logic       full
);

  lbp_entry_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_r;
  logic [FIFO_AW-1:0]    rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `LBP_ASSERT_IMP(a_fifo_no_overflow, push, !full, "push into full queue")
  `LBP_ASSERT_IMP(a_fifo_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// ----- rtl/lbp_back.sv -----
// Back end: line buffers, 3x3 window, pattern code and output register.
`timescale 1ns / 1ps

module lbp_back import lbp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  lbp_entry_t       head,
  input  logic             fifo_empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,
  output logic             out_tlast
);

  logic [PIX_W-1:0] upper_line_r  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line_r [MAX_WIDTH];
  logic [PIX_W-1:0] win_r   [9];
  logic [PIX_W-1:0] win_nxt [9];
  logic [PIX_W-1:0] up_rd_r;
  logic [PIX_W-1:0] mid_rd_r;
  lbp_entry_t       b_item_r;
  logic             b_valid_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  logic             needs_out;
  logic             out_free;
  logic             b_exec;
  logic             b_take;
  logic             wr_en;
  logic [PIX_W-1:0] code;
  logic [PIX_W-1:0] result;
  logic [PIX_W-1:0] ctr;

  assign needs_out = b_item_r.kind != KIND_PIXEL;
  assign out_free  = !out_valid_r || out_tready;
  assign b_exec    = b_valid_r && (!needs_out || out_free);
  assign b_take    = !b_valid_r || b_exec;
  assign pop       = b_take && !fifo_empty;
  assign wr_en     = b_exec && (b_item_r.kind != KIND_DRAIN_OUT);

  // window index is column * 3 + row, column 0 oldest
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_nxt[i] = win_r[i+3];
    end
    win_nxt[6] = up_rd_r;
    win_nxt[7] = mid_rd_r;
    win_nxt[8] = b_item_r.pixel;

    ctr  = win_nxt[4];
    code = {win_nxt[0] > ctr, win_nxt[3] > ctr, win_nxt[6] > ctr, win_nxt[7] > ctr,
            win_nxt[8] > ctr, win_nxt[5] > ctr, win_nxt[2] > ctr, win_nxt[1] > ctr};

    unique case (b_item_r.kind)
      KIND_PIXEL_OUT: result = b_item_r.border ? ctr : code;
      KIND_DRAIN_OUT: result = b_item_r.sel_upper ? up_rd_r : mid_rd_r;
      default:        result = ctr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_line_r[b_item_r.addr]  <= mid_rd_r;
      middle_line_r[b_item_r.addr] <= b_item_r.pixel;
    end
  end

  // read with bypass of the write retiring in the same cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      if (wr_en && (b_item_r.addr == head.addr)) begin
        up_rd_r  <= mid_rd_r;
        mid_rd_r <= b_item_r.pixel;
      end else begin
        up_rd_r  <= upper_line_r[head.addr];
        mid_rd_r <= middle_line_r[head.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item_r <= head;
    end
    if (b_exec && needs_out) begin
      out_data_r <= result;
      out_last_r <= b_item_r.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (b_take) begin
        b_valid_r <= !fifo_empty;
      end
      if (b_exec && needs_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/lbp_pixel_operator.sv -----
// Top level of the 3x3 local binary pattern operator: front end, entry queue, back end.
// Throughput: one word per clock in and out unless stalled; results leave from an output register.
// Results trail the pixel stream by frame_width+1 pixel words; drain words flush the tail.
// A frame_width write stalls input while the bit-serial divider re-derives the output
// row and column; any other write stalls input while the settle register is set.
// Reset (rst_n low, synchronous) clears counters, window, queue and output; line buffers keep data.
`timescale 1ns / 1ps

module lbp_pixel_operator import lbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_value
  input  logic                  in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // [7:0] lbp_code
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic       fifo_full;
  logic       fifo_empty;
  logic       push;
  logic       pop;
  lbp_entry_t push_entry;
  lbp_entry_t head;

  lbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lbp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (fifo_empty),
    .full       (fifo_full)
  );

  lbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the 3x3 LBP pixel operator stream block.
`timescale 1ns / 1ps

module tb_top;
  import lbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned TAIL_CYCLES = 12;

  typedef struct packed {
    logic [PIX_W-1:0] code;
    logic             eof;
  } lbp_word_t;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pix;
    logic             typed;
    logic             has_word;
    lbp_word_t        word;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [PIX_W-1:0] in_tdata = '0;  // [7:0] pixel_value
  logic in_tuser = OP_PIXEL;        // [0] opcode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;      // [7:0] lbp_code
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [WIDTH_W-1:0] cur_width;
  logic [HEIGHT_W-1:0] cur_height;
  logic [PIX_W-1:0] line_up [MAX_WIDTH];
  logic [PIX_W-1:0] line_mid [MAX_WIDTH];
  bit up_seen [MAX_WIDTH];
  bit mid_seen [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned out_pos;
  int unsigned fill_cnt;

  lbp_word_t expected_words [$];
  stim_row_t directed_rows [25];
  int unsigned fed_items = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  lbp_pixel_operator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lbp_pixel_operator] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_out
    lbp_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: code=%02h last=%b", out_tdata, out_tlast);
      end else begin
        want = expected_words.pop_front();
        if (out_tdata !== want.code || out_tlast !== want.eof) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected code=%02h last=%b, got code=%02h last=%b",
                     want.code, want.eof, out_tdata, out_tlast);
        end
      end
    end
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cur_width;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (cur_height == 0) ? 1 : cur_height;
  endfunction

  function automatic logic [PIX_W-1:0] pattern_of_window();
    logic [PIX_W-1:0] code;
    code[7] = win[0] > win[4];
    code[6] = win[3] > win[4];
    code[5] = win[6] > win[4];
    code[4] = win[7] > win[4];
    code[3] = win[8] > win[4];
    code[2] = win[5] > win[4];
    code[1] = win[2] > win[4];
    code[0] = win[1] > win[4];
    return code;
  endfunction

  // both line buffers hold data for every column of the current width
  function automatic bit lines_ready(int unsigned w);
    for (int i = 0; i < w; i++)
      if (!up_seen[i] || !mid_seen[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_word(input logic op, input logic [PIX_W-1:0] pix,
                              output bit produced, output lbp_word_t word);
    int unsigned w, h, col, orow, ocol;
    logic [PIX_W-1:0] v;
    w = eff_width();
    h = eff_height();
    produced = 1'b0;
    word = '0;
    v = '0;
    if (op == OP_PIXEL) begin
      col = (col_pos < MAX_WIDTH) ? col_pos : 0;
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = line_up[col];
      win[7] = line_mid[col];
      win[8] = pix;
      line_up[col] = line_mid[col];
      up_seen[col] = mid_seen[col];
      line_mid[col] = pix;
      mid_seen[col] = 1'b1;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
      fill_cnt++;
      if (fill_cnt > w + 1) begin
        orow = out_pos / w;
        ocol = out_pos % w;
        fill_cnt--;
        v = (orow == 0 || orow + 1 >= h || ocol == 0 || ocol + 1 >= w) ?
            win[4] : pattern_of_window();
        produced = 1'b1;
      end
    end else if (fill_cnt > 0 && row_pos == 0 && col_pos == 0) begin
      ocol = out_pos % w;
      v = (fill_cnt > w) ? line_up[ocol] : line_mid[ocol];
      fill_cnt--;
      produced = 1'b1;
    end
    if (produced) begin
      word.code = v;
      word.eof = (out_pos + 1 >= w * h);
      out_pos = word.eof ? 0 : ((out_pos + 1) & 32'h3FFFFF);
    end
  endtask

  task automatic send_word(input logic op, input logic [PIX_W-1:0] pix, input bit typed,
                           input bit typed_has, input lbp_word_t typed_word);
    bit produced;
    lbp_word_t word;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(op, pix, produced, word);
    if (op == OP_PIXEL || produced) fed_items++;
    if (typed) begin
      produced = typed_has;
      word = typed_word;
    end
    if (produced) expected_words.push_back(word);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) cur_width = val[WIDTH_W-1:0];
    else cur_height = val[HEIGHT_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic flush_pipe();
    while (fill_cnt > 0) send_word(OP_DRAIN, $urandom_range(255), 1'b0, 1'b0, '0);
  endtask

  task automatic run_phase(input int unsigned wv, input int unsigned hv,
                           input int unsigned nframes, input int unsigned mode,
                           input bit noisy);
    int unsigned pix_total;
    logic [PIX_W-1:0] base;
    bit narrow;
    wait_idle();
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
    write_reg(REG_FRAME_WIDTH, wv);
    write_reg(REG_FRAME_HEIGHT, hv);
    pix_total = eff_width() * eff_height() * nframes;
    narrow = $urandom_range(1);
    base = $urandom_range(253);
    for (int unsigned k = 0; k < pix_total; k++) begin
      // stray drains; at a frame boundary only when the pipe is empty or the line buffers are filled
      if (noisy && $urandom_range(99) < 5 &&
          (row_pos != 0 || col_pos != 0 || fill_cnt == 0 || lines_ready(eff_width())))
        send_word(OP_DRAIN, $urandom_range(255), 1'b0, 1'b0, '0);
      send_word(OP_PIXEL, narrow ? base + $urandom_range(2) : $urandom_range(255),
                1'b0, 1'b0, '0);
    end
    flush_pipe();
  endtask

  initial begin
    int unsigned start_fed;
    int unsigned phase_no;
    cur_width = WIDTH_RESET;
    cur_height = HEIGHT_RESET;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_up[i] = '0;
      line_mid[i] = '0;
      up_seen[i] = 1'b0;
      mid_seen[i] = 1'b0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    row_pos = 0;
    col_pos = 0;
    out_pos = 0;
    fill_cnt = 0;

    // 3x3 frame: a b c / d e f / g h i, center pattern 8'hAA
    directed_rows = '{
      '{OP_DRAIN, 8'h5A, 1'b1, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b1, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd0, 1'b1, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd129, 1'b1, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd0, 1'b1, 1'b0, '{8'h00, 1'b0}},
      '{OP_DRAIN, 8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd128, 1'b1, 1'b1, '{8'd255, 1'b0}},
      '{OP_PIXEL, 8'd128, 1'b1, 1'b1, '{8'd0, 1'b0}},
      '{OP_PIXEL, 8'd200, 1'b1, 1'b1, '{8'd129, 1'b0}},
      '{OP_PIXEL, 8'd127, 1'b1, 1'b1, '{8'd0, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b1, 1'b1, '{8'hAA, 1'b0}},
      '{OP_DRAIN, 8'h00, 1'b1, 1'b1, '{8'd128, 1'b0}},
      '{OP_DRAIN, 8'h00, 1'b1, 1'b1, '{8'd200, 1'b0}},
      '{OP_DRAIN, 8'h00, 1'b1, 1'b1, '{8'd127, 1'b0}},
      '{OP_DRAIN, 8'h00, 1'b1, 1'b1, '{8'd255, 1'b1}},
      '{OP_DRAIN, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd0, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, 1'b0, '{8'h00, 1'b0}}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].pix, directed_rows[i].typed,
                directed_rows[i].has_word, directed_rows[i].word);
    flush_pipe();

    run_phase(1, 1, 5, 1, 1'b0);
    run_phase(2047, 1, 1, 2, 1'b0);
    run_phase(1024, 3, 1, 3, 1'b0);
    run_phase(0, 4095, 1, 0, 1'b0);
    run_phase(9, 0, 2, 1, 1'b0);
    run_phase(2, 2, 2, 2, 1'b1);

    start_fed = fed_items;
    phase_no = 0;
    while (fed_items - start_fed < RANDOM_ITEMS) begin
      run_phase(($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12),
                ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8),
                $urandom_range(1, 3), phase_no % 4, 1'b1);
      phase_no++;
    end

    wait_idle();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[lbp_pixel_operator] OK");
    end else begin
      $display("[lbp_pixel_operator] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lbp_pkg.sv
rtl/lbp_div.sv
rtl/lbp_front.sv
rtl/lbp_fifo.sv
rtl/lbp_back.sv
rtl/lbp_pixel_operator.sv
dv/tb_top.sv
